// File: hw/rtl/tlssni_pkg.sv
// Shared types and constants for the TLS server-name extension parser.
`timescale 1ns / 1ps
`default_nettype none
package tlssni_pkg;

  // Extension id and entry type of interest
  localparam logic [15:0] SNI_EXTENSION_ID     = 16'd0;
  localparam logic [7:0]  HOST_NAME_ENTRY_TYPE = 8'd0;

  // Result kinds
  localparam logic KIND_NAME_BYTE = 1'b0;
  localparam logic KIND_STATUS    = 1'b1;

  // Status codes
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // Saturation value of the byte counter
  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  // Default depth of the result queue
  localparam int RESULT_DEPTH_DEFAULT = 4;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic [1:0] status;
    logic       found;
    logic       last;
  } result_t;

  // Host-name character check: letters, digits, '-' and '.'
  function automatic logic name_char_ok(input logic [7:0] c);
    logic ok;
    ok = ((c >= 8'h30) && (c <= 8'h39)) ||
         ((c >= 8'h61) && (c <= 8'h7A)) ||
         ((c >= 8'h41) && (c <= 8'h5A)) ||
         (c == 8'h2D) || (c == 8'h2E);
    return ok;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tlssni_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
`timescale 1ns / 1ps
`default_nettype none
module tlssni_fifo #(
  parameter int DEPTH = tlssni_pkg::RESULT_DEPTH_DEFAULT
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire  [1:0]               push_n,
  input  wire  tlssni_pkg::result_t push_d0,
  input  wire  tlssni_pkg::result_t push_d1,
  output logic                     room_two,
  output logic                     out_valid,
  input  wire                      out_ready,
  output tlssni_pkg::result_t      out_d
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tlssni_pkg::result_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr1;
  logic [PW-1:0] wr_ptr2;
  logic [PW-1:0] rd_ptr1;
  logic          pop;

  // Wrap pointers
  assign wr_ptr1 = (wr_ptr  == PW'(DEPTH - 1)) ? '0 : wr_ptr  + 1'b1;
  assign wr_ptr2 = (wr_ptr1 == PW'(DEPTH - 1)) ? '0 : wr_ptr1 + 1'b1;
  assign rd_ptr1 = (rd_ptr  == PW'(DEPTH - 1)) ? '0 : rd_ptr  + 1'b1;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_d     = mem[rd_ptr];
  assign room_two  = (count <= CW'(DEPTH - 2));

  // Store entries
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= push_d1;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (push_n)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wr_ptr2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tls_sni_extension_parser.sv
// Top level: byte-wise parser of the TLS server-name extension.
//
// Input channel (in_valid/in_ready) carries one item per transfer: ext_id,
// data_byte, byte_present and last_byte. The parse state is updated in the
// cycle of the transfer and the results go into a small result queue.
// Output channel (out_valid/out_ready) carries one result per transfer: a
// host-name byte (result_kind 0) or the closing status (result_kind 1,
// last_result 1) with status and name_found.
// Each result is written into the registered result queue at its input transfer.
// Throughput: one item per cycle while the receiver keeps up; an item that
// gives both a name byte and a status needs two output transfers, so the
// rate is set by the output port, one result per cycle.
// in_ready is high while the queue (RESULT_DEPTH entries) has room for two
// results; when the receiver stalls the queue fills and in_ready drops, and
// no result is lost.
// Reset clears the parse state and empties the queue; the state also
// returns to its reset values after every closing status.
`timescale 1ns / 1ps
`default_nettype none
module tls_sni_extension_parser #(
  parameter int RESULT_DEPTH = tlssni_pkg::RESULT_DEPTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] ext_id,
  input  wire  [7:0]  data_byte,
  input  wire         byte_present,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        result_kind,
  output logic [7:0]  name_byte,
  output logic [1:0]  status,
  output logic        name_found,
  output logic        last_result
);

  typedef enum logic [2:0] {
    PH_LIST_HI = 3'd0,
    PH_LIST_LO = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_SKIP    = 3'd5,
    PH_HOST    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [16:0] byte_position, byte_position_next;
  logic [15:0] list_size, list_size_next;
  logic [15:0] entry_remaining, entry_remaining_next;
  logic [7:0]  entry_type, entry_type_next;
  logic [1:0]  first_error, first_error_next;
  logic        host_found, host_found_next;
  logic        sni_mode, sni_mode_next;

  logic        accept;
  logic        room_two;
  logic        emit;
  logic [15:0] rem_dec;
  logic [15:0] len_full;
  logic [1:0]  st;
  logic        found;
  logic [1:0]  push_n;
  tlssni_pkg::result_t byte_res, stat_res, push_d0, push_d1, out_d;

  assign in_ready = room_two;
  assign accept   = in_valid && in_ready;

  // Parse one item
  always_comb begin
    parse_phase_next     = parse_phase;
    byte_position_next   = byte_position;
    list_size_next       = list_size;
    entry_remaining_next = entry_remaining;
    entry_type_next      = entry_type;
    first_error_next     = first_error;
    host_found_next      = host_found;
    sni_mode_next        = sni_mode;
    emit                 = 1'b0;
    rem_dec              = entry_remaining - 16'd1;
    len_full             = {entry_remaining[15:8], data_byte};

    // Latch the extension id before the first byte
    if ((byte_position == '0) && (byte_present || last_byte)) begin
      sni_mode_next = (ext_id == tlssni_pkg::SNI_EXTENSION_ID);
    end

    if (byte_present) begin
      if (byte_position != tlssni_pkg::POS_MAX) begin
        byte_position_next = byte_position + 17'd1;
      end
      if (sni_mode_next) begin
        unique case (parse_phase)
          PH_LIST_HI: begin
            list_size_next   = {data_byte, 8'h00};
            parse_phase_next = PH_LIST_LO;
          end
          PH_LIST_LO: begin
            list_size_next   = {list_size[15:8], data_byte};
            parse_phase_next = PH_TYPE;
          end
          PH_TYPE: begin
            entry_type_next  = data_byte;
            parse_phase_next = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            entry_remaining_next = {data_byte, 8'h00};
            parse_phase_next     = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            entry_remaining_next = len_full;
            if (entry_type == tlssni_pkg::HOST_NAME_ENTRY_TYPE) begin
              if (len_full == '0) begin
                host_found_next  = 1'b1;
                parse_phase_next = PH_DONE;
              end else begin
                parse_phase_next = PH_HOST;
              end
            end else begin
              parse_phase_next = (len_full == '0) ? PH_TYPE : PH_SKIP;
            end
          end
          PH_SKIP: begin
            entry_remaining_next = rem_dec;
            if (rem_dec == '0) begin
              parse_phase_next = PH_TYPE;
            end
          end
          PH_HOST: begin
            if (!tlssni_pkg::name_char_ok(data_byte) &&
                (first_error == tlssni_pkg::ST_SUCCESS)) begin
              first_error_next = tlssni_pkg::ST_ILLEGAL;
            end
            emit                 = 1'b1;
            entry_remaining_next = rem_dec;
            if (rem_dec == '0) begin
              host_found_next  = 1'b1;
              parse_phase_next = PH_DONE;
            end
          end
          PH_DONE: begin
            parse_phase_next = PH_DONE;
          end
          default: begin
            parse_phase_next = parse_phase;
          end
        endcase
      end
    end

    // Closing status, length mismatch first
    priority if (!sni_mode_next) begin
      st = tlssni_pkg::ST_SUCCESS;
    end else if ((byte_position_next < 17'd2) ||
                 ((17'(list_size_next) + 17'd2) != byte_position_next)) begin
      st = tlssni_pkg::ST_LENGTH;
    end else if ((parse_phase_next == PH_SKIP) || (parse_phase_next == PH_HOST)) begin
      st = tlssni_pkg::ST_LENGTH;
    end else begin
      st = first_error_next;
    end
    found = sni_mode_next && (st == tlssni_pkg::ST_SUCCESS) && host_found_next;

    // Return to reset values after the status
    if (last_byte) begin
      parse_phase_next     = PH_LIST_HI;
      byte_position_next   = '0;
      list_size_next       = '0;
      entry_remaining_next = '0;
      entry_type_next      = '0;
      first_error_next     = tlssni_pkg::ST_SUCCESS;
      host_found_next      = 1'b0;
      sni_mode_next        = 1'b1;
    end
  end

  // Build results for the queue
  always_comb begin
    byte_res.kind      = tlssni_pkg::KIND_NAME_BYTE;
    byte_res.name_byte = data_byte;
    byte_res.status    = tlssni_pkg::ST_SUCCESS;
    byte_res.found     = 1'b0;
    byte_res.last      = 1'b0;

    stat_res.kind      = tlssni_pkg::KIND_STATUS;
    stat_res.name_byte = 8'h00;
    stat_res.status    = st;
    stat_res.found     = found;
    stat_res.last      = 1'b1;

    push_d0 = emit ? byte_res : stat_res;
    push_d1 = stat_res;
    if (accept) begin
      push_n = 2'(emit) + 2'(last_byte);
    end else begin
      push_n = 2'd0;
    end
  end

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_LIST_HI;
      byte_position   <= '0;
      list_size       <= '0;
      entry_remaining <= '0;
      entry_type      <= '0;
      first_error     <= tlssni_pkg::ST_SUCCESS;
      host_found      <= 1'b0;
      sni_mode        <= 1'b1;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      byte_position   <= byte_position_next;
      list_size       <= list_size_next;
      entry_remaining <= entry_remaining_next;
      entry_type      <= entry_type_next;
      first_error     <= first_error_next;
      host_found      <= host_found_next;
      sni_mode        <= sni_mode_next;
    end
  end

  tlssni_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_d     (out_d)
  );

  // Drive result fields
  assign result_kind = out_d.kind;
  assign name_byte   = out_d.name_byte;
  assign status      = out_d.status;
  assign name_found  = out_d.found;
  assign last_result = out_d.last;

endmodule
`default_nettype wire
